// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, masked while rst_ni is low.
`define DSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dsa assertion failed");

// Concurrent check on clk_i that also holds during reset.
`define DSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dsa assertion failed");

`endif

// ===== src/dsa_pkg.sv =====
package dsa_pkg;

  localparam int unsigned WORD_W            = 32;
  localparam int unsigned FIELD_WORDS       = 3;
  localparam int unsigned SCALE_W           = 5;
  localparam int unsigned MANTISSA_WORDS_DEF = 3;
  localparam int unsigned SCALE_LIMIT_DEF    = 28;

  // One input transaction: two operands.
  typedef struct packed {
    logic [WORD_W-1:0]  a_low_word;
    logic [WORD_W-1:0]  a_mid_word;
    logic [WORD_W-1:0]  a_high_word;
    logic [SCALE_W-1:0] a_scale;
    logic               a_negative;
    logic [WORD_W-1:0]  b_low_word;
    logic [WORD_W-1:0]  b_mid_word;
    logic [WORD_W-1:0]  b_high_word;
    logic [SCALE_W-1:0] b_scale;
    logic               b_negative;
  } in_item_t;

  // One output transaction: aligned operands and overflow flag.
  typedef struct packed {
    logic [WORD_W-1:0]  a_low_out;
    logic [WORD_W-1:0]  a_mid_out;
    logic [WORD_W-1:0]  a_high_out;
    logic [SCALE_W-1:0] a_scale_out;
    logic               a_negative_out;
    logic [WORD_W-1:0]  b_low_out;
    logic [WORD_W-1:0]  b_mid_out;
    logic [WORD_W-1:0]  b_high_out;
    logic [SCALE_W-1:0] b_scale_out;
    logic               b_negative_out;
    logic               overflow;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dsa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need;
    logic carry;
  } dsa_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } dsa_state_e;

endpackage

// ===== src/dsa_in_if.sv =====
interface dsa_in_if;
  import dsa_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/dsa_out_if.sv =====
interface dsa_out_if;
  import dsa_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/decimal_scale_align_top.sv =====
// Decimal scale alignment: takes two 96-bit decimal operands (mantissa,
// power-of-ten scale, sign) and multiplies the mantissa of the operand with
// the smaller scale by ten until both scales match, raising its scale by
// one per step (never past SCALE_LIMIT). If a step carries out of the
// mantissa, both operands come back unchanged with overflow set. One
// transaction is in flight at a time: the result is registered at commit,
// and the next input is taken in the cycle after the result commits. The
// number of multiply-by-ten steps is the scale difference, capped by
// SCALE_LIMIT, or fewer when a carry stops the run; one shared
// shift-and-add unit performs one step per cycle. The result sits in an
// output register, so a stalled sink delays only the next commit.
module decimal_scale_align_top #(
  parameter int unsigned MANTISSA_WORDS = dsa_pkg::MANTISSA_WORDS_DEF,
  parameter int unsigned SCALE_LIMIT    = dsa_pkg::SCALE_LIMIT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsa_in_if.sink    in_i,
  dsa_out_if.source out_o
);
  import dsa_pkg::*;

  dsa_cmd_t    cmd;
  dsa_status_t sts;

  dsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsa_datapath #(
    .MANTISSA_WORDS (MANTISSA_WORDS),
    .SCALE_LIMIT    (SCALE_LIMIT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_i.data),
    .out_data_o (out_o.data)
  );

endmodule

// ===== src/dsa_datapath.sv =====
`include "assert_macros.svh"

module dsa_datapath #(
  parameter int unsigned MANTISSA_WORDS = dsa_pkg::MANTISSA_WORDS_DEF,
  parameter int unsigned SCALE_LIMIT    = dsa_pkg::SCALE_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsa_pkg::dsa_cmd_t   cmd_i,
  output dsa_pkg::dsa_status_t sts_o,
  input  dsa_pkg::in_item_t   in_data_i,
  output dsa_pkg::out_item_t  out_data_o
);
  import dsa_pkg::*;

  localparam int unsigned MW = WORD_W * MANTISSA_WORDS;

  logic [FIELD_WORDS-1:0][WORD_W-1:0] a_in_words, b_in_words;
  logic [MW-1:0]      a_in_mant, b_in_mant;

  logic [MW-1:0]      a_mant_q, b_mant_q, w_mant_q;
  logic [SCALE_W-1:0] a_scale_q, b_scale_q, w_scale_q, tgt_q;
  logic               a_neg_q, b_neg_q, sel_b_q;
  out_item_t          res_q;

  logic [MW+3:0]      prod;
  logic               need, carry, ovf;
  logic [MW-1:0]      a_res_mant, b_res_mant;
  logic [SCALE_W-1:0] a_res_scale, b_res_scale;
  logic [FIELD_WORDS-1:0][WORD_W-1:0] a_res_words, b_res_words;
  logic               sel_b_in;

  assign a_in_words = {in_data_i.a_high_word, in_data_i.a_mid_word, in_data_i.a_low_word};
  assign b_in_words = {in_data_i.b_high_word, in_data_i.b_mid_word, in_data_i.b_low_word};

  // Map field words onto the mantissa; words above the fields enter as zero.
  for (genvar gi = 0; gi < MANTISSA_WORDS; gi++) begin : g_load
    if (gi < FIELD_WORDS) begin : g_word
      assign a_in_mant[WORD_W*gi +: WORD_W] = a_in_words[gi];
      assign b_in_mant[WORD_W*gi +: WORD_W] = b_in_words[gi];
    end else begin : g_zero
      assign a_in_mant[WORD_W*gi +: WORD_W] = '0;
      assign b_in_mant[WORD_W*gi +: WORD_W] = '0;
    end
  end

  // Multiply the working mantissa by ten: x*8 + x*2.
  assign prod  = {1'b0, w_mant_q, 3'b000} + {3'b000, w_mant_q, 1'b0};
  assign carry = |prod[MW+3:MW];
  assign need  = (w_scale_q < tgt_q) &&
                 ({{(32-SCALE_W){1'b0}}, w_scale_q} < 32'(SCALE_LIMIT));
  assign ovf   = need && carry;

  assign sts_o.need  = need;
  assign sts_o.carry = carry;

  assign sel_b_in = in_data_i.a_scale > in_data_i.b_scale;

  // Capture operands and set up the raised operand.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_mant_q  <= a_in_mant;
      b_mant_q  <= b_in_mant;
      a_scale_q <= in_data_i.a_scale;
      b_scale_q <= in_data_i.b_scale;
      a_neg_q   <= in_data_i.a_negative;
      b_neg_q   <= in_data_i.b_negative;
      sel_b_q   <= sel_b_in;
      w_mant_q  <= sel_b_in ? b_in_mant : a_in_mant;
      w_scale_q <= sel_b_in ? in_data_i.b_scale : in_data_i.a_scale;
      tgt_q     <= sel_b_in ? in_data_i.a_scale : in_data_i.b_scale;
    end else if (cmd_i.step) begin
      w_mant_q  <= prod[MW-1:0];
      w_scale_q <= w_scale_q + SCALE_W'(1);
    end
  end

  // Pick raised or original operands; overflow keeps both unchanged.
  always_comb begin
    a_res_mant  = (sel_b_q || ovf) ? a_mant_q : w_mant_q;
    a_res_scale = (sel_b_q || ovf) ? a_scale_q : w_scale_q;
    b_res_mant  = (!sel_b_q || ovf) ? b_mant_q : w_mant_q;
    b_res_scale = (!sel_b_q || ovf) ? b_scale_q : w_scale_q;
  end

  // Mantissa words beyond the configured width read as zero.
  for (genvar gi = 0; gi < FIELD_WORDS; gi++) begin : g_store
    if (gi < MANTISSA_WORDS) begin : g_word
      assign a_res_words[gi] = a_res_mant[WORD_W*gi +: WORD_W];
      assign b_res_words[gi] = b_res_mant[WORD_W*gi +: WORD_W];
    end else begin : g_zero
      assign a_res_words[gi] = '0;
      assign b_res_words[gi] = '0;
    end
  end

  // Hold the result until the next commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.a_low_out      <= a_res_words[0];
      res_q.a_mid_out      <= a_res_words[1];
      res_q.a_high_out     <= a_res_words[2];
      res_q.a_scale_out    <= a_res_scale;
      res_q.a_negative_out <= a_neg_q;
      res_q.b_low_out      <= b_res_words[0];
      res_q.b_mid_out      <= b_res_words[1];
      res_q.b_high_out     <= b_res_words[2];
      res_q.b_scale_out    <= b_res_scale;
      res_q.b_negative_out <= b_neg_q;
      res_q.overflow       <= ovf;
    end
  end

  assign out_data_o = res_q;

  `DSA_ASSERT(a_step_bound, cmd_i.step |=> (w_scale_q <= tgt_q))

endmodule

// ===== src/dsa_ctrl.sv =====
`include "assert_macros.svh"

module dsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dsa_pkg::dsa_status_t sts_i,
  output dsa_pkg::dsa_cmd_t    cmd_o
);
  import dsa_pkg::*;

  dsa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequence load, multiply steps and commit of one transaction.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.need && !sts_i.carry) begin
          cmd_o.step = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DSA_ASSERT(a_commit_slot, cmd_o.commit |-> (!out_valid_q || out_ready_i))
  `DSA_ASSERT_ALWAYS(a_cmd_excl, !(cmd_o.step && (cmd_o.commit || cmd_o.load)))
  `DSA_ASSERT(a_load_run, cmd_o.load |=> (state_q == S_RUN && !in_ready_o))

endmodule
